// ----- design/woo_pkg.sv -----
// shared types, constants and helpers for the wire outline offset block
`default_nettype none
package woo_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ACC_W     = 128;
	localparam int DIFF_W    = 33;
	localparam int HW_W      = 30;
	localparam int MULB_W    = 33;
	localparam int LEN_W     = 33 + FRAC_BITS;
	localparam int MAG_W     = 35;
	localparam int CORR_W    = MAG_W + 1;
	localparam int CNT_W     = 8;
	localparam int DIV_STEPS  = ACC_W;
	localparam int SQRT_STEPS = ACC_W / 2;
	localparam int MUL_STEPS  = MULB_W;
	localparam logic [MAG_W-1:0] CORR_MAX = MAG_W'(1) << (MAG_W - 1);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_LEN = 2'd1,
		ST_SINGLE   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_MUL  = 2'd0,
		OP_DIV  = 2'd1,
		OP_SQRT = 2'd2
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic [30:0]        wire_width;
		logic               last_point;
	} in_t;

	typedef struct packed {
		logic signed [31:0] left_x;
		logic signed [31:0] left_y;
		logic signed [31:0] right_x;
		logic signed [31:0] right_y;
		logic [1:0]         status;
		logic               last_result;
	} out_t;

	typedef enum logic [4:0] {
		S_IDLE, S_ECHK, S_EDX2, S_EDY2, S_ESQRT, S_EMX, S_EDIVX, S_EMY, S_EDIVY,
		S_MCHK, S_MP1, S_MP2, S_MA2, S_MB2, S_MSQ1, S_MA3, S_MB3, S_MSQ2,
		S_MN1, S_MN2, S_MN3, S_MN4, S_MWX, S_MDX, S_MWY, S_MDY, S_EMIT
	} state_t;

	function automatic logic [DIFF_W-1:0] mag33(input logic signed [DIFF_W-1:0] v);
		return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
	endfunction

	function automatic logic [ACC_W-1:0] ext33(input logic [DIFF_W-1:0] v);
		return {{(ACC_W-DIFF_W){1'b0}}, v};
	endfunction

	function automatic logic [ACC_W-1:0] neg_if(input logic [ACC_W-1:0] v, input logic neg);
		return neg ? (ACC_W'(0) - v) : v;
	endfunction

	// round to nearest, ties to even, then clamp the magnitude
	function automatic logic [MAG_W-1:0] rnd(input logic [ACC_W-1:0] q);
		logic [FRAC_BITS-1:0] fr;
		logic [FRAC_BITS-1:0] half;
		logic [ACC_W-1:0]     ip;
		logic                 up;
		logic [MAG_W:0]       s;
		fr   = q[FRAC_BITS-1:0];
		half = FRAC_BITS'(1) << (FRAC_BITS - 1);
		ip   = q >> FRAC_BITS;
		up   = (fr > half) || ((fr == half) && ip[0]);
		s    = {1'b0, ip[MAG_W-1:0]} + (MAG_W+1)'(up);
		if (|ip[ACC_W-1:MAG_W])
			return CORR_MAX;
		else if (s > {1'b0, CORR_MAX})
			return CORR_MAX;
		else
			return s[MAG_W-1:0];
	endfunction

	function automatic logic signed [CORR_W-1:0] corr(input logic [MAG_W-1:0] m,
			input logic neg);
		return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [CORR_W:0] v);
		if (v > (CORR_W+1)'(signed'(32'h7fffffff)))
			return 32'sh7fffffff;
		else if (v < -(CORR_W+1)'(signed'(33'h080000000)))
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage
`default_nettype wire

// ----- design/woo_alu.sv -----
// shared iterative unit: shift-add multiply, restoring divide, integer square root
`default_nettype none
module woo_alu (
	input  wire                         clk,
	input  wire                         arst_n,
	input  woo_pkg::alu_req_t           req,
	input  wire [woo_pkg::ACC_W-1:0]    opa,
	input  wire [woo_pkg::ACC_W-1:0]    opb,
	output logic                        done,
	output logic [woo_pkg::ACC_W-1:0]   res
);
	logic                          busy_q;
	logic                          done_q;
	woo_pkg::alu_op_t              op_q;
	logic [woo_pkg::CNT_W-1:0]     cnt_q;
	logic [woo_pkg::ACC_W-1:0]     acc_q;
	logic [woo_pkg::ACC_W-1:0]     x_q;
	logic [woo_pkg::ACC_W-1:0]     y_q;
	logic [woo_pkg::ACC_W-1:0]     q_q;
	logic [woo_pkg::ACC_W-1:0]     rem;
	logic [woo_pkg::ACC_W-1:0]     trial;
	logic [woo_pkg::CNT_W-1:0]     last_cnt;

	assign rem   = {acc_q[woo_pkg::ACC_W-2:0], x_q[woo_pkg::ACC_W-1]};
	assign trial = x_q + y_q;

	always_comb begin
		unique case (op_q)
			woo_pkg::OP_MUL:  last_cnt = woo_pkg::CNT_W'(woo_pkg::MUL_STEPS - 1);
			woo_pkg::OP_DIV:  last_cnt = woo_pkg::CNT_W'(woo_pkg::DIV_STEPS - 1);
			woo_pkg::OP_SQRT: last_cnt = woo_pkg::CNT_W'(woo_pkg::SQRT_STEPS - 1);
			default:          last_cnt = '0;
		endcase
	end

	always_comb begin
		unique case (op_q)
			woo_pkg::OP_DIV:  res = q_q;
			woo_pkg::OP_SQRT: res = x_q;
			default:          res = acc_q;
		endcase
	end

	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= woo_pkg::OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (!busy_q && req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
			end else if (busy_q && cnt_q == last_cnt) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && req.start) begin
			cnt_q <= '0;
			q_q   <= '0;
			unique case (req.op)
				woo_pkg::OP_SQRT: begin
					acc_q <= opa;
					x_q   <= '0;
					y_q   <= woo_pkg::ACC_W'(1) << (woo_pkg::ACC_W - 2);
				end
				default: begin
					acc_q <= '0;
					x_q   <= opa;
					y_q   <= opb;
				end
			endcase
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			unique case (op_q)
				woo_pkg::OP_MUL: begin
					if (y_q[0])
						acc_q <= acc_q + x_q;
					x_q <= x_q << 1;
					y_q <= y_q >> 1;
				end
				woo_pkg::OP_DIV: begin
					if (rem >= y_q) begin
						acc_q <= rem - y_q;
						q_q   <= {q_q[woo_pkg::ACC_W-2:0], 1'b1};
					end else begin
						acc_q <= rem;
						q_q   <= {q_q[woo_pkg::ACC_W-2:0], 1'b0};
					end
					x_q <= x_q << 1;
				end
				woo_pkg::OP_SQRT: begin
					if (acc_q >= trial) begin
						acc_q <= acc_q - trial;
						x_q   <= (x_q >> 1) + y_q;
					end else begin
						x_q <= x_q >> 1;
					end
					y_q <= y_q >> 2;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- design/wire_outline_offset.sv -----
// top level: wire outline offset sequencer, state and result register
`default_nettype none
// Turns the centerline points of a wire into left/right outline points, one
// pair per vertex. Vertex k is answered when point k+1 arrives; the last point
// answers its inner vertex and its own end vertex together. A single point
// with last_point set answers status 2. All multiplies, divides and square
// roots run through one shared iterative unit under the sequencer here. That
// unit does a shift-add multiply in 33 steps, a restoring divide in 128 steps
// and a square root in 64 steps. Each operation also takes a step to start it
// and a step to hand back the result. A transaction that causes no result
// (first point) leaves the sequencer idle. The input is not ready while a
// vertex is being worked on. A finished result sits in the output register
// while the next point is taken. The sequencer waits there only if the next
// result is ready before the previous one has left.
module wire_outline_offset (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_ready,
	input  woo_pkg::in_t  in_data,
	output logic          out_valid,
	input  wire           out_ready,
	output woo_pkg::out_t out_data
);
	localparam int AW = woo_pkg::ACC_W;
	localparam int DW = woo_pkg::DIFF_W;

	woo_pkg::state_t state_q, state_d;

	// wire state
	logic signed [31:0]           older_x_q, older_y_q, newer_x_q, newer_y_q;
	logic [1:0]                   seen_q;
	logic [woo_pkg::HW_W-1:0]     hw_q;

	// current point transaction
	logic signed [31:0]           item_x_q, item_y_q;
	logic                         item_last_q;

	// vertex job
	logic signed [31:0]           vx_q, vy_q;
	logic signed [DW-1:0]         ax_q, ay_q, bx_q, by_q;
	logic [AW-1:0]                acc_q, d_q, nx_q, ny_q;
	logic [woo_pkg::LEN_W-1:0]    l1_q, l2_q;
	logic signed [woo_pkg::CORR_W-1:0] xc_q, yc_q;
	logic [1:0]                   st_q;
	logic                         lr_q;

	// result register
	logic                         out_valid_q;
	woo_pkg::out_t                out_q;

	// shared unit
	woo_pkg::alu_req_t            req;
	logic [AW-1:0]                opa, opb;
	logic                         alu_done;
	logic [AW-1:0]                alu_res;
	logic                         issued_q;
	logic                         op_state;

	logic                         accept;
	logic                         can_load;
	logic                         second_due;
	logic [DW-1:0]                ax_m, ay_m, bx_m, by_m;
	logic [AW-1:0]                nx_m, ny_m, d_m, d_new;
	logic                         b_zero;
	woo_pkg::out_t                res_d;

	woo_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.opa    (opa),
		.opb    (opb),
		.done   (alu_done),
		.res    (alu_res)
	);

	assign ax_m = woo_pkg::mag33(ax_q);
	assign ay_m = woo_pkg::mag33(ay_q);
	assign bx_m = woo_pkg::mag33(bx_q);
	assign by_m = woo_pkg::mag33(by_q);
	assign nx_m = woo_pkg::neg_if(nx_q, nx_q[AW-1]);
	assign ny_m = woo_pkg::neg_if(ny_q, ny_q[AW-1]);
	assign d_m  = woo_pkg::neg_if(d_q, d_q[AW-1]);
	assign b_zero = (bx_q == '0) && (by_q == '0);
	// cross product D = x32*y21 - x21*y32
	assign d_new = acc_q - woo_pkg::neg_if(alu_res, ax_q[DW-1] ^ by_q[DW-1]);

	assign accept     = in_valid && in_ready;
	assign can_load   = !out_valid_q || out_ready;
	// last point still owes its own end vertex
	assign second_due = (seen_q != 2'd0) && item_last_q && !lr_q;

	assign in_ready  = (state_q == woo_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			woo_pkg::S_IDLE: begin
				if (accept) begin
					if (seen_q == 2'd0)
						state_d = in_data.last_point ? woo_pkg::S_EMIT : woo_pkg::S_IDLE;
					else if (seen_q == 2'd1)
						state_d = woo_pkg::S_ECHK;
					else
						state_d = woo_pkg::S_MCHK;
				end
			end
			woo_pkg::S_ECHK:
				state_d = (ax_q == '0 && ay_q == '0) ? woo_pkg::S_EMIT : woo_pkg::S_EDX2;
			woo_pkg::S_MCHK:
				state_d = b_zero ? woo_pkg::S_EMIT : woo_pkg::S_MP1;
			woo_pkg::S_EMIT: begin
				if (can_load)
					state_d = second_due ? woo_pkg::S_ECHK : woo_pkg::S_IDLE;
			end
			default: begin
				if (alu_done) begin
					unique case (state_q)
						woo_pkg::S_EDX2:  state_d = woo_pkg::S_EDY2;
						woo_pkg::S_EDY2:  state_d = woo_pkg::S_ESQRT;
						woo_pkg::S_ESQRT: state_d = woo_pkg::S_EMX;
						woo_pkg::S_EMX:   state_d = woo_pkg::S_EDIVX;
						woo_pkg::S_EDIVX: state_d = woo_pkg::S_EMY;
						woo_pkg::S_EMY:   state_d = woo_pkg::S_EDIVY;
						woo_pkg::S_EDIVY: state_d = woo_pkg::S_EMIT;
						woo_pkg::S_MP1:   state_d = woo_pkg::S_MP2;
						woo_pkg::S_MP2:
							state_d = (d_new == '0) ? woo_pkg::S_EDX2 : woo_pkg::S_MA2;
						woo_pkg::S_MA2:   state_d = woo_pkg::S_MB2;
						woo_pkg::S_MB2:   state_d = woo_pkg::S_MSQ1;
						woo_pkg::S_MSQ1:  state_d = woo_pkg::S_MA3;
						woo_pkg::S_MA3:   state_d = woo_pkg::S_MB3;
						woo_pkg::S_MB3:   state_d = woo_pkg::S_MSQ2;
						woo_pkg::S_MSQ2:  state_d = woo_pkg::S_MN1;
						woo_pkg::S_MN1:   state_d = woo_pkg::S_MN2;
						woo_pkg::S_MN2:   state_d = woo_pkg::S_MN3;
						woo_pkg::S_MN3:   state_d = woo_pkg::S_MN4;
						woo_pkg::S_MN4:   state_d = woo_pkg::S_MWX;
						woo_pkg::S_MWX:   state_d = woo_pkg::S_MDX;
						woo_pkg::S_MDX:   state_d = woo_pkg::S_MWY;
						woo_pkg::S_MWY:   state_d = woo_pkg::S_MDY;
						woo_pkg::S_MDY:   state_d = woo_pkg::S_EMIT;
						default:          state_d = woo_pkg::S_IDLE;
					endcase
				end
			end
		endcase
	end

	// unit operation and operands per step
	always_comb begin
		op_state = 1'b1;
		req.op   = woo_pkg::OP_MUL;
		opa      = '0;
		opb      = '0;
		unique case (state_q)
			woo_pkg::S_EDX2:  begin opa = woo_pkg::ext33(ax_m); opb = woo_pkg::ext33(ax_m); end
			woo_pkg::S_EDY2:  begin opa = woo_pkg::ext33(ay_m); opb = woo_pkg::ext33(ay_m); end
			woo_pkg::S_ESQRT: begin
				req.op = woo_pkg::OP_SQRT;
				opa    = acc_q << (2 * woo_pkg::FRAC_BITS);
			end
			woo_pkg::S_EMX: begin
				opa = woo_pkg::ext33(ay_m);
				opb = AW'(hw_q);
			end
			woo_pkg::S_EMY: begin
				opa = woo_pkg::ext33(ax_m);
				opb = AW'(hw_q);
			end
			woo_pkg::S_EDIVX, woo_pkg::S_EDIVY: begin
				req.op = woo_pkg::OP_DIV;
				opa    = acc_q << (2 * woo_pkg::FRAC_BITS);
				opb    = AW'(l1_q);
			end
			woo_pkg::S_MP1:   begin opa = woo_pkg::ext33(bx_m); opb = woo_pkg::ext33(ay_m); end
			woo_pkg::S_MP2:   begin opa = woo_pkg::ext33(ax_m); opb = woo_pkg::ext33(by_m); end
			woo_pkg::S_MA2:   begin opa = woo_pkg::ext33(ax_m); opb = woo_pkg::ext33(ax_m); end
			woo_pkg::S_MB2:   begin opa = woo_pkg::ext33(ay_m); opb = woo_pkg::ext33(ay_m); end
			woo_pkg::S_MA3:   begin opa = woo_pkg::ext33(bx_m); opb = woo_pkg::ext33(bx_m); end
			woo_pkg::S_MB3:   begin opa = woo_pkg::ext33(by_m); opb = woo_pkg::ext33(by_m); end
			woo_pkg::S_MSQ1, woo_pkg::S_MSQ2: begin
				req.op = woo_pkg::OP_SQRT;
				opa    = acc_q << (2 * woo_pkg::FRAC_BITS);
			end
			woo_pkg::S_MN1:   begin opa = AW'(l1_q); opb = woo_pkg::ext33(bx_m); end
			woo_pkg::S_MN2:   begin opa = AW'(l2_q); opb = woo_pkg::ext33(ax_m); end
			woo_pkg::S_MN3:   begin opa = AW'(l2_q); opb = woo_pkg::ext33(ay_m); end
			woo_pkg::S_MN4:   begin opa = AW'(l1_q); opb = woo_pkg::ext33(by_m); end
			woo_pkg::S_MWX:   begin opa = nx_m; opb = AW'(hw_q); end
			woo_pkg::S_MWY:   begin opa = ny_m; opb = AW'(hw_q); end
			woo_pkg::S_MDX, woo_pkg::S_MDY: begin
				req.op = woo_pkg::OP_DIV;
				opa    = acc_q;
				opb    = d_m;
			end
			default: op_state = 1'b0;
		endcase
		req.start = op_state && !issued_q;
	end

	// result formation
	always_comb begin
		res_d.status      = st_q;
		res_d.last_result = lr_q;
		if (st_q != woo_pkg::ST_OK) begin
			res_d.left_x  = '0;
			res_d.left_y  = '0;
			res_d.right_x = '0;
			res_d.right_y = '0;
		end else begin
			res_d.left_x  = woo_pkg::sat32((woo_pkg::CORR_W+1)'(vx_q) - (woo_pkg::CORR_W+1)'(xc_q));
			res_d.left_y  = woo_pkg::sat32((woo_pkg::CORR_W+1)'(vy_q) + (woo_pkg::CORR_W+1)'(yc_q));
			res_d.right_x = woo_pkg::sat32((woo_pkg::CORR_W+1)'(vx_q) + (woo_pkg::CORR_W+1)'(xc_q));
			res_d.right_y = woo_pkg::sat32((woo_pkg::CORR_W+1)'(vy_q) - (woo_pkg::CORR_W+1)'(yc_q));
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= woo_pkg::S_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			seen_q      <= 2'd0;
			older_x_q   <= '0;
			older_y_q   <= '0;
			newer_x_q   <= '0;
			newer_y_q   <= '0;
			hw_q        <= '0;
		end else begin
			state_q <= state_d;
			if (req.start)
				issued_q <= 1'b1;
			else if (alu_done)
				issued_q <= 1'b0;

			if (state_q == woo_pkg::S_EMIT && can_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			if (accept && seen_q == 2'd0) begin
				hw_q <= in_data.wire_width[30:1];
				if (!in_data.last_point) begin
					newer_x_q <= in_data.point_x;
					newer_y_q <= in_data.point_y;
					seen_q    <= 2'd1;
				end
			end

			if (state_q == woo_pkg::S_EMIT && can_load) begin
				// wire state moves on once the point's last result is out
				if (!second_due && seen_q != 2'd0) begin
					if (item_last_q) begin
						seen_q <= 2'd0;
					end else begin
						older_x_q <= newer_x_q;
						older_y_q <= newer_y_q;
						newer_x_q <= item_x_q;
						newer_y_q <= item_y_q;
						seen_q    <= 2'd2;
					end
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == woo_pkg::S_EMIT && can_load)
			out_q <= res_d;

		if (accept) begin
			item_x_q    <= in_data.point_x;
			item_y_q    <= in_data.point_y;
			item_last_q <= in_data.last_point;
			vx_q        <= newer_x_q;
			vy_q        <= newer_y_q;
			if (seen_q == 2'd0) begin
				st_q <= woo_pkg::ST_SINGLE;
				lr_q <= 1'b1;
			end else begin
				st_q <= woo_pkg::ST_OK;
				lr_q <= 1'b0;
				if (seen_q == 2'd1) begin
					ax_q <= DW'(in_data.point_x) - DW'(newer_x_q);
					ay_q <= DW'(in_data.point_y) - DW'(newer_y_q);
				end else begin
					ax_q <= DW'(newer_x_q) - DW'(older_x_q);
					ay_q <= DW'(newer_y_q) - DW'(older_y_q);
					bx_q <= DW'(in_data.point_x) - DW'(newer_x_q);
					by_q <= DW'(in_data.point_y) - DW'(newer_y_q);
				end
			end
		end

		unique case (state_q)
			woo_pkg::S_ECHK: begin
				if (ax_q == '0 && ay_q == '0)
					st_q <= woo_pkg::ST_ZERO_LEN;
			end
			woo_pkg::S_MCHK: begin
				if (b_zero)
					st_q <= woo_pkg::ST_ZERO_LEN;
			end
			woo_pkg::S_EMIT: begin
				// end vertex of the last point, along the final segment
				if (can_load && second_due) begin
					vx_q <= item_x_q;
					vy_q <= item_y_q;
					ax_q <= DW'(item_x_q) - DW'(newer_x_q);
					ay_q <= DW'(item_y_q) - DW'(newer_y_q);
					lr_q <= 1'b1;
					st_q <= woo_pkg::ST_OK;
				end
			end
			default: begin
				if (alu_done) begin
					unique case (state_q)
						woo_pkg::S_EDX2, woo_pkg::S_MA2, woo_pkg::S_MA3,
						woo_pkg::S_EMX, woo_pkg::S_EMY, woo_pkg::S_MWX, woo_pkg::S_MWY:
							acc_q <= alu_res;
						woo_pkg::S_EDY2, woo_pkg::S_MB2, woo_pkg::S_MB3:
							acc_q <= acc_q + alu_res;
						woo_pkg::S_ESQRT, woo_pkg::S_MSQ1:
							l1_q <= alu_res[woo_pkg::LEN_W-1:0];
						woo_pkg::S_MSQ2:
							l2_q <= alu_res[woo_pkg::LEN_W-1:0];
						woo_pkg::S_EDIVX:
							xc_q <= woo_pkg::corr(woo_pkg::rnd(alu_res), ay_q[DW-1]);
						woo_pkg::S_EDIVY:
							yc_q <= woo_pkg::corr(woo_pkg::rnd(alu_res), ax_q[DW-1]);
						woo_pkg::S_MP1:
							acc_q <= woo_pkg::neg_if(alu_res, bx_q[DW-1] ^ ay_q[DW-1]);
						woo_pkg::S_MP2: begin
							d_q <= d_new;
							// collinear: offset along the outgoing segment
							if (d_new == '0) begin
								ax_q <= bx_q;
								ay_q <= by_q;
							end
						end
						woo_pkg::S_MN1:
							nx_q <= woo_pkg::neg_if(alu_res, bx_q[DW-1]);
						woo_pkg::S_MN2:
							nx_q <= nx_q - woo_pkg::neg_if(alu_res, ax_q[DW-1]);
						woo_pkg::S_MN3:
							ny_q <= woo_pkg::neg_if(alu_res, ay_q[DW-1]);
						woo_pkg::S_MN4:
							ny_q <= ny_q - woo_pkg::neg_if(alu_res, by_q[DW-1]);
						woo_pkg::S_MDX:
							xc_q <= woo_pkg::corr(woo_pkg::rnd(alu_res), nx_q[AW-1] ^ d_q[AW-1]);
						woo_pkg::S_MDY:
							yc_q <= woo_pkg::corr(woo_pkg::rnd(alu_res), ny_q[AW-1] ^ d_q[AW-1]);
						default: begin
							acc_q <= acc_q;
						end
					endcase
				end
			end
		endcase
	end
endmodule
`default_nettype wire

// ----- test/wire_outline_offset_test.sv -----
// testbench for the wire outline offset block: directed and random centerline points checked against a predictor
`default_nettype none
module wire_outline_offset_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM   = 1650;
	localparam int WATCHDOG   = 20000;
	localparam int HOLD_LONG  = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	woo_pkg::in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	woo_pkg::out_t out_data;

	wire_outline_offset u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #4 clk = ~clk;

	// predictor state: the two latest points, how many were seen, half width
	logic signed [63:0] prev_x, prev_y, cur_x, cur_y;
	int unsigned        pts_seen;
	logic [63:0]        half_w;

	woo_pkg::in_t  point_queue[$];
	woo_pkg::out_t outline_queue[$];
	int   errors = 0;
	int   mismatches = 0;
	bit   stim_done = 0;
	bit   quiet_tail = 0;
	bit   hold_off = 0;
	int   idle_cycles = 0;
	bit   timed_out = 0;

	function automatic void queue_point(input woo_pkg::in_t p);
		point_queue.insert(point_queue.size(), p);
	endfunction

	function automatic void queue_outline(input woo_pkg::out_t o);
		outline_queue.insert(outline_queue.size(), o);
	endfunction

	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [127:0] root128(input logic [127:0] n);
		logic [127:0] res, bitv, t;
		res = '0;
		bitv = 128'(1) << 126;
		while (bitv != 0 && n < bitv) bitv = bitv >> 2;
		while (bitv != 0) begin
			t = res + bitv;
			if (n >= t) begin
				n = n - t;
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [127:0] seg_length(input logic signed [63:0] dx,
			input logic signed [63:0] dy);
		logic [127:0] s;
		s = 128'(mag(dx)) * 128'(mag(dx)) + 128'(mag(dy)) * 128'(mag(dy));
		return root128(s << (2 * woo_pkg::FRAC_BITS));
	endfunction

	// round to nearest even on the fraction, then clamp at 2^34
	function automatic logic [63:0] round_mag(input logic [127:0] q);
		logic [127:0] ip;
		logic [woo_pkg::FRAC_BITS-1:0] fr;
		fr = q[woo_pkg::FRAC_BITS-1:0];
		ip = q >> woo_pkg::FRAC_BITS;
		if (fr > (1 << (woo_pkg::FRAC_BITS - 1))
				|| (fr == (1 << (woo_pkg::FRAC_BITS - 1)) && ip[0]))
			ip = ip + 128'(1);
		if (ip > (128'(1) << 34))
			return 64'(1) << 34;
		return ip[63:0];
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sh7fffffff)
			return 32'sh7fffffff;
		if (v < -64'sh80000000)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic woo_pkg::out_t make_pair(input logic signed [63:0] vx, vy, xc, yc,
			input woo_pkg::status_t st, input logic lst);
		woo_pkg::out_t o;
		o = '0;
		if (st == woo_pkg::ST_OK) begin
			o.left_x  = clamp32(vx - xc);
			o.left_y  = clamp32(vy + yc);
			o.right_x = clamp32(vx + xc);
			o.right_y = clamp32(vy - yc);
		end
		o.status = st;
		o.last_result = lst;
		return o;
	endfunction

	function automatic woo_pkg::out_t end_offset(input logic signed [63:0] vx, vy, dx, dy,
			input logic lst);
		logic [127:0] len;
		logic [63:0] mx, my;
		logic signed [63:0] xc, yc;
		if (dx == 0 && dy == 0)
			return make_pair(0, 0, 0, 0, woo_pkg::ST_ZERO_LEN, lst);
		len = seg_length(dx, dy);
		mx = round_mag((128'(half_w * mag(dy)) << (2 * woo_pkg::FRAC_BITS)) / len);
		my = round_mag((128'(half_w * mag(dx)) << (2 * woo_pkg::FRAC_BITS)) / len);
		xc = dy < 0 ? -$signed(mx) : $signed(mx);
		yc = dx < 0 ? -$signed(my) : $signed(my);
		return make_pair(vx, vy, xc, yc, woo_pkg::ST_OK, lst);
	endfunction

	function automatic woo_pkg::out_t miter_offset(input logic signed [63:0] x3, y3);
		logic signed [63:0] x21, y21, x32, y32;
		logic signed [127:0] d, nx, ny;
		logic [127:0] l1, l2, ad, anx, any_;
		logic [63:0] mx, my;
		logic signed [63:0] xc, yc;
		x21 = cur_x - prev_x;
		y21 = cur_y - prev_y;
		x32 = x3 - cur_x;
		y32 = y3 - cur_y;
		if (x32 == 0 && y32 == 0)
			return make_pair(0, 0, 0, 0, woo_pkg::ST_ZERO_LEN, 1'b0);
		d = 128'(x32) * 128'(y21) - 128'(x21) * 128'(y32);
		// collinear or repeated vertex: offset along the outgoing segment
		if (d == 0)
			return end_offset(cur_x, cur_y, x32, y32, 1'b0);
		l1 = seg_length(x21, y21);
		l2 = seg_length(x32, y32);
		nx = 128'(x32) * $signed(l1) - 128'(x21) * $signed(l2);
		ny = 128'(y21) * $signed(l2) - 128'(y32) * $signed(l1);
		ad = d < 0 ? 128'(-d) : 128'(d);
		anx = nx < 0 ? 128'(-nx) : 128'(nx);
		any_ = ny < 0 ? 128'(-ny) : 128'(ny);
		mx = round_mag((anx * 128'(half_w)) / ad);
		my = round_mag((any_ * 128'(half_w)) / ad);
		xc = ((nx < 0) != (d < 0)) ? -$signed(mx) : $signed(mx);
		yc = ((ny < 0) != (d < 0)) ? -$signed(my) : $signed(my);
		return make_pair(cur_x, cur_y, xc, yc, woo_pkg::ST_OK, 1'b0);
	endfunction

	// advance the predictor by one accepted point
	task automatic predict_outline(input woo_pkg::in_t p);
		logic signed [63:0] x, y;
		x = 64'(p.point_x);
		y = 64'(p.point_y);
		if (pts_seen == 0) begin
			half_w = 64'(p.wire_width >> 1);
			if (p.last_point) begin
				queue_outline(make_pair(0, 0, 0, 0, woo_pkg::ST_SINGLE, 1'b1));
			end else begin
				cur_x = x;
				cur_y = y;
				pts_seen = 1;
			end
		end else begin
			if (pts_seen == 1)
				queue_outline(end_offset(cur_x, cur_y, x - cur_x, y - cur_y, 1'b0));
			else
				queue_outline(miter_offset(x, y));
			if (p.last_point) begin
				queue_outline(end_offset(x, y, x - cur_x, y - cur_y, 1'b1));
				pts_seen = 0;
			end else begin
				prev_x = cur_x;
				prev_y = cur_y;
				cur_x = x;
				cur_y = y;
				pts_seen = 2;
			end
		end
	endtask

	// coordinate with a mix of extremes, small values and full range
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2, 3: return 32'($signed($urandom_range(0, 40)) - 20);
			4, 5, 6: return 32'($signed($urandom_range(0, 200000)) - 100000);
			default: return $urandom;
		endcase
	endfunction

	function automatic woo_pkg::in_t mk_point(input logic [31:0] x, y, input logic [30:0] w,
			input logic lst);
		woo_pkg::in_t p;
		p.point_x = x;
		p.point_y = y;
		p.wire_width = w;
		p.last_point = lst;
		return p;
	endfunction

	// fill the point queue: directed wires first, then random ones
	initial begin
		int n, len;
		logic [31:0] bx, by;
		logic [30:0] w;
		// single point wire
		queue_point(mk_point(32'd5, 32'd7, 31'h7fffffff, 1'b1));
		// two points at the coordinate extremes, widest width
		queue_point(mk_point(32'h80000000, 32'h80000000, 31'h7fffffff, 1'b0));
		queue_point(mk_point(32'h7fffffff, 32'h7fffffff, 31'd0, 1'b1));
		// zero-length end segment, then a miter, a collinear and a repeated vertex
		queue_point(mk_point(32'd0, 32'd0, 31'd100, 1'b0));
		queue_point(mk_point(32'd0, 32'd0, 31'd0, 1'b0));
		queue_point(mk_point(32'd10, 32'd0, 31'd0, 1'b0));
		queue_point(mk_point(32'd10, 32'd10, 31'd0, 1'b0));
		queue_point(mk_point(32'd10, 32'd20, 31'd0, 1'b0));
		queue_point(mk_point(32'd10, 32'd20, 31'd0, 1'b0));
		queue_point(mk_point(-32'sd30, 32'd20, 31'd0, 1'b1));
		// sharp turn with odd width and zero width
		queue_point(mk_point(32'd0, 32'd0, 31'd7, 1'b0));
		queue_point(mk_point(32'd1000, 32'd1, 31'd0, 1'b0));
		queue_point(mk_point(32'd0, 32'd2, 31'd0, 1'b1));
		queue_point(mk_point(-32'sd5, -32'sd5, 31'd0, 1'b0));
		queue_point(mk_point(32'd5, -32'sd5, 31'd1, 1'b0));
		queue_point(mk_point(32'h7fffffff, 32'h80000000, 31'd0, 1'b1));
		n = point_queue.size();
		while (n < N_RANDOM) begin
			len = $urandom_range(1, 6);
			case ($urandom_range(0, 3))
				0: w = 31'($urandom);
				1: w = 31'($urandom_range(0, 64));
				default: w = 31'($urandom_range(0, 1000000));
			endcase
			bx = rand_coord();
			by = rand_coord();
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 3) != 0 && i > 0) begin
					bx = bx + 32'($signed($urandom_range(0, 2000)) - 1000);
					by = by + 32'($signed($urandom_range(0, 2000)) - 1000);
				end else if (i > 0) begin
					bx = rand_coord();
					by = rand_coord();
				end
				queue_point(mk_point(bx, by, w, i == len - 1));
				n++;
			end
		end
		stim_done = 1;
	end

	// reset, then a long receiver hold-off early in the run
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (40) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_LONG) @(posedge clk);
		hold_off <= 1'b0;
	end

	// driver: keeps valid up until the transaction is taken, random gaps
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_outline(in_data);
				void'(point_queue.pop_front());
			end
			if (!(in_valid && !in_ready)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
					gap_left <= $urandom_range(0, 6);
					in_valid <= 1'b0;
				end else if (point_queue.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= point_queue[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// quiet last part of the run: no idling on either side
	always @(posedge clk)
		if (stim_done && point_queue.size() < 150)
			quiet_tail <= 1'b1;

	// monitor and receiver stalls
	int stall_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (outline_queue.size() == 0) begin
					errors++;
					if (mismatches++ < 10)
						$display("unexpected outline transaction %p", out_data);
				end else begin
					if (out_data !== outline_queue[0]) begin
						errors++;
						if (mismatches++ < 10)
							$display("mismatch: expected %p actual %p",
								outline_queue[0], out_data);
					end
					void'(outline_queue.pop_front());
				end
			end
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
				stall_left <= $urandom_range(0, 6);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog: cycles in which no transaction happens
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG + HOLD_LONG)
			timed_out = 1;
	end

	// end of run
	initial begin
		wait (timed_out || (stim_done && point_queue.size() == 0 && !in_valid
			&& outline_queue.size() == 0));
		if (!timed_out)
			repeat (1000) @(posedge clk);
		if (!timed_out && errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
